// ===== hdl/hashed_token_bigram_embedder_macros.svh =====
// Assertion shorthands shared by the checkers of this block.
`ifndef HASHED_TOKEN_BIGRAM_EMBEDDER_MACROS_SVH
`define HASHED_TOKEN_BIGRAM_EMBEDDER_MACROS_SVH

// same-cycle implication
`define HBE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbe checker: same-cycle rule violated");

// next-cycle implication
`define HBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbe checker: next-cycle rule violated");

`endif

// ===== hdl/hbe_pkg.sv =====
`default_nettype none

package hbe_pkg;

	localparam int MAX_DIMENSION = 64;
	localparam int ACC_W = 24;

	localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [7:0] PAIR_SEP = 8'h1F;
	localparam logic [2:0] TOKEN_WEIGHT = 3'd5;
	localparam logic [2:0] BIGRAM_WEIGHT = 3'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic byte_present;
		logic end_of_text;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] element_value;
		logic [5:0] element_index;
		logic last_element;
	} out_item_t;

	// divisor is up to 2*sqrt < 2^33
	typedef struct packed {
		logic go;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quo;
		logic [32:0] rem;
	} div_rsp_t;

	// one FNV-1a byte step; prime is 2^40 + 0x1B3, done as shifts and adds
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] c);
		logic [63:0] x;
		x = h ^ {56'd0, c};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [63:0] empty_hash();
		logic [55:0] word;
		logic [63:0] h;
		word = "<empty>";
		h = FNV_BASIS;
		for (int i = 0; i < 7; i++) begin
			h = fnv_step(h, word[55 - 8 * i -: 8]);
		end
		return h;
	endfunction

	localparam logic [63:0] EMPTY_HASH = empty_hash();

endpackage

`default_nettype wire

// ===== hdl/hbe_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle, 64 steps
module hbe_div import hbe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] div_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [33:0] part;
	logic [33:0] diff;
	logic ge;

	assign part = {rem_q, quo_q[63]};
	assign diff = part - {1'b0, div_q};
	assign ge = part >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= !req.go && run_q && (cnt_q == 6'd63);
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[32:0] : part[32:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;

endmodule

`default_nettype wire

// ===== hdl/hashed_token_bigram_embedder.sv =====
`default_nettype none

// Hashed token/bigram text embedder. Feed one text byte per transaction with
// start while busy is low; the last transaction of a text carries end_of_text.
// Tokens (lower-cased ASCII alphanumerics plus bytes 0x80 and up) and adjacent
// token pairs are FNV-1a-64 hashed into a signed 24-bit saturating store of
// dimension_in_use entries (clamped to 8..MaxDim). At end of text the store is
// L2-normalized and streamed out as signed Q2.14, one element per cycle-long
// done strobe, element 0 first, last_element on the final one. The receiver
// cannot stall: every done pulse must be captured when it occurs.
// Datapath: one FNV step unit, one 64-step shift/subtract divider and an
// iterative square root, sharing a small sequencer. A token byte is accepted,
// then the bigram FNV step runs. A token close makes a store update (hash
// modulo on the divider), two updates once a previous token exists, then a
// finishing step. End of text runs a sum-of-squares pass, a normalize shift
// and the square root, then one division per element, then clears the store.
// Reset leaves the store empty at once (per-entry valid bits), no sweep.
// Configuration: one APB register, not decoded by paddr, dimension_in_use
// (7 bits, reset 64); write it only while busy is low.
module hashed_token_bigram_embedder import hbe_pkg::*; #(
	parameter int MaxDim = MAX_DIMENSION
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic start,
	output logic busy,
	input wire in_item_t item,
	output logic done,
	output out_item_t result
);

	localparam int IDX_W = $clog2(MaxDim);
	localparam int DIM_W = $clog2(MaxDim + 1);

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_FNV_B   = 16'h0002,
		S_MOD_GO  = 16'h0004,
		S_MOD     = 16'h0008,
		S_UPD_RD  = 16'h0010,
		S_UPD_WR  = 16'h0020,
		S_CL_FIN  = 16'h0040,
		S_SUM_RD  = 16'h0080,
		S_SUM_MUL = 16'h0100,
		S_SUM_ACC = 16'h0200,
		S_SHIFT   = 16'h0400,
		S_SQRT    = 16'h0800,
		S_EM_RD   = 16'h1000,
		S_EM_DIV  = 16'h2000,
		S_EM_WAIT = 16'h4000,
		S_CLEAR   = 16'h8000
	} state_t;

	// which hash a store update belongs to
	typedef enum logic [1:0] {
		K_TOK = 2'd0,
		K_BIG = 2'd1,
		K_EMP = 2'd2
	} kind_t;

	state_t state_q;
	kind_t kind_q;

	logic [6:0] dim_q;
	logic [DIM_W-1:0] dim_use;

	logic [63:0] token_q;
	logic [63:0] bigram_q;
	logic inside_q;
	logic prev_q;
	logic eot_q;
	logic [7:0] c_q;

	logic [63:0] add_h_q;
	logic [2:0] add_w_q;
	logic [IDX_W-1:0] pos_q;

	logic [DIM_W-1:0] cnt_q;
	logic [46:0] sq_q;
	logic [63:0] sum_q;   // sum of squares, then shifted, then sqrt remainder
	logic [4:0] s_q;
	logic [63:0] res_q;   // square root result
	logic [4:0] k_q;
	logic neg_q;

	logic done_q;
	out_item_t result_q;

	// store
	logic [ACC_W-1:0] mem [MaxDim];
	logic [MaxDim-1:0] valid_q;
	logic [ACC_W-1:0] rd_q;
	logic rdv_q;
	logic [IDX_W-1:0] mem_addr;
	logic signed [ACC_W-1:0] ent;

	// byte classification
	logic [7:0] b;
	logic in_keep;
	logic [7:0] in_c;

	// shared FNV step
	logic [63:0] fnv_h;
	logic [7:0] fnv_c;
	logic [63:0] fnv_out;

	// saturating store update
	logic [ACC_W:0] upd_sum;
	logic [ACC_W-1:0] upd_val;

	logic signed [2*ACC_W-1:0] prod;
	logic [ACC_W-1:0] mag;
	logic [63:0] num;
	logic [63:0] sum_next;
	logic [63:0] bitv;
	logic [63:0] cand;
	logic r_zero;
	logic last_el;
	logic [15:0] q_val;
	logic cfg_wr;

	div_req_t dreq;
	div_rsp_t drsp;

	hbe_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// clamp of the programmed dimension
	always_comb begin
		if (dim_q < 7'd8) begin
			dim_use = DIM_W'(8);
		end else if (32'(dim_q) > MaxDim) begin
			dim_use = DIM_W'(MaxDim);
		end else begin
			dim_use = DIM_W'(dim_q);
		end
	end

	assign b = item.text_byte;
	always_comb begin
		in_keep = 1'b0;
		in_c = b;
		if (b >= 8'h80 || (b >= "0" && b <= "9") || (b >= "a" && b <= "z")) begin
			in_keep = 1'b1;
		end else if (b >= "A" && b <= "Z") begin
			in_keep = 1'b1;
			in_c = b + 8'd32;
		end
	end

	always_comb begin
		if (state_q == S_FNV_B) begin
			fnv_h = bigram_q;
			fnv_c = c_q;
		end else if (state_q == S_CL_FIN) begin
			fnv_h = token_q;
			fnv_c = PAIR_SEP;
		end else begin
			fnv_h = token_q;
			fnv_c = in_c;
		end
	end
	assign fnv_out = fnv_step(fnv_h, fnv_c);

	assign mem_addr = (state_q == S_UPD_RD) ? pos_q : cnt_q[IDX_W-1:0];
	assign ent = rdv_q ? rd_q : '0;

	// bit 32 of the hash picks subtract
	assign upd_sum = {ent[ACC_W-1], ent}
		+ (add_h_q[32] ? ((ACC_W+1)'(0) - (ACC_W+1)'(add_w_q)) : (ACC_W+1)'(add_w_q));
	always_comb begin
		if (upd_sum[ACC_W] != upd_sum[ACC_W-1]) begin
			upd_val = upd_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			upd_val = upd_sum[ACC_W-1:0];
		end
	end

	assign prod = ent * ent;
	assign sum_next = sum_q + 64'(sq_q);

	assign bitv = 64'd1 << {k_q, 1'b0};
	assign cand = res_q + bitv;

	assign mag = ent[ACC_W-1] ? ACC_W'(-ent) : ent;
	// (2*16384*a + r) / (2r) with a = |v| << s
	assign num = ((64'(mag) << s_q) << 15) + 64'(res_q[31:0]);
	assign r_zero = (res_q[31:0] == 32'd0);
	assign q_val = r_zero ? 16'd0 : drsp.quo[15:0];
	assign last_el = (DIM_W'(cnt_q + 1'b1) == dim_use);

	always_comb begin
		dreq.go = 1'b0;
		dreq.dividend = add_h_q;
		dreq.divisor = 33'(dim_use);
		if (state_q == S_MOD_GO) begin
			dreq.go = 1'b1;
		end else if (state_q == S_EM_DIV) begin
			dreq.go = !r_zero;
			dreq.dividend = num;
			// r reaches 2^32 - 1, so 2r needs 33 bits
			dreq.divisor = {res_q[31:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD_WR) begin
			mem[pos_q] <= upd_val;
		end
		rd_q <= mem[mem_addr];
		rdv_q <= valid_q[mem_addr];
	end

	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 7'd64;
		end else if (cfg_wr) begin
			dim_q <= pwdata[6:0];
		end
	end

	// one-cycle strobe per emitted element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_EM_WAIT) && (r_zero || drsp.done);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= K_TOK;
			token_q <= FNV_BASIS;
			bigram_q <= '0;
			inside_q <= 1'b0;
			prev_q <= 1'b0;
			eot_q <= 1'b0;
			c_q <= '0;
			add_h_q <= '0;
			add_w_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			sq_q <= '0;
			sum_q <= '0;
			s_q <= '0;
			res_q <= '0;
			k_q <= '0;
			neg_q <= 1'b0;
			valid_q <= '0;
			result_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					sum_q <= '0;
					s_q <= '0;
					if (start) begin
						eot_q <= item.end_of_text;
						c_q <= in_c;
						if (item.byte_present && in_keep) begin
							token_q <= fnv_out;
							inside_q <= 1'b1;
							state_q <= S_FNV_B;
						end else if (inside_q && (item.byte_present || item.end_of_text)) begin
							add_h_q <= token_q;
							add_w_q <= TOKEN_WEIGHT;
							kind_q <= K_TOK;
							state_q <= S_MOD_GO;
						end else if (item.end_of_text) begin
							state_q <= S_SUM_RD;
						end
					end
				end
				S_FNV_B: begin
					bigram_q <= fnv_out;
					if (eot_q) begin
						add_h_q <= token_q;
						add_w_q <= TOKEN_WEIGHT;
						kind_q <= K_TOK;
						state_q <= S_MOD_GO;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MOD_GO: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (drsp.done) begin
						pos_q <= drsp.rem[IDX_W-1:0];
						state_q <= S_UPD_RD;
					end
				end
				S_UPD_RD: begin
					state_q <= S_UPD_WR;
				end
				S_UPD_WR: begin
					valid_q[pos_q] <= 1'b1;
					unique case (kind_q)
						K_TOK: begin
							if (prev_q) begin
								add_h_q <= bigram_q;
								add_w_q <= BIGRAM_WEIGHT;
								kind_q <= K_BIG;
								state_q <= S_MOD_GO;
							end else begin
								state_q <= S_CL_FIN;
							end
						end
						K_BIG: state_q <= S_CL_FIN;
						K_EMP: begin
							// only entry is +-5
							sum_q <= 64'd25;
							state_q <= S_SHIFT;
						end
						default: state_q <= S_CL_FIN;
					endcase
				end
				S_CL_FIN: begin
					bigram_q <= fnv_out;
					prev_q <= 1'b1;
					token_q <= FNV_BASIS;
					inside_q <= 1'b0;
					state_q <= eot_q ? S_SUM_RD : S_IDLE;
				end
				S_SUM_RD: begin
					state_q <= S_SUM_MUL;
				end
				S_SUM_MUL: begin
					sq_q <= prod[46:0];
					state_q <= S_SUM_ACC;
				end
				S_SUM_ACC: begin
					sum_q <= sum_next;
					if (last_el) begin
						cnt_q <= '0;
						if (sum_next == 64'd0) begin
							add_h_q <= EMPTY_HASH;
							add_w_q <= TOKEN_WEIGHT;
							kind_q <= K_EMP;
							state_q <= S_MOD_GO;
						end else begin
							state_q <= S_SHIFT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_SUM_RD;
					end
				end
				S_SHIFT: begin
					if (sum_q != 64'd0 && sum_q[63:60] == 4'd0) begin
						sum_q <= sum_q << 2;
						s_q <= s_q + 5'd1;
					end else begin
						res_q <= '0;
						k_q <= 5'd31;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sum_q >= cand) begin
						sum_q <= sum_q - cand;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
					if (k_q == 5'd0) begin
						cnt_q <= '0;
						state_q <= S_EM_RD;
					end else begin
						k_q <= k_q - 5'd1;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_DIV;
				end
				S_EM_DIV: begin
					neg_q <= ent[ACC_W-1];
					state_q <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (r_zero || drsp.done) begin
						result_q.element_value <= neg_q ? (16'd0 - q_val) : q_val;
						result_q.element_index <= 6'(cnt_q[IDX_W-1:0]);
						result_q.last_element <= last_el;
						cnt_q <= cnt_q + 1'b1;
						state_q <= last_el ? S_CLEAR : S_EM_RD;
					end
				end
				S_CLEAR: begin
					valid_q <= '0;
					token_q <= FNV_BASIS;
					bigram_q <= '0;
					inside_q <= 1'b0;
					prev_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;
	assign prdata = 32'(dim_q);
	assign pready = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/hbe_checker.sv =====
`default_nettype none

`include "hashed_token_bigram_embedder_macros.svh"

module hbe_checker import hbe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic done,
	input wire out_item_t result
);

	// results only come out of a running embedding
	`HBE_ASSERT_NOW(a_done_busy, done, busy)
	// each element needs a division, never two strobes in a row
	`HBE_ASSERT_NEXT(a_done_gap, done, !done)
	// more elements pending keeps the block busy
	`HBE_ASSERT_NEXT(a_more_busy, done && !result.last_element, busy)
	// the last element is followed by the clear, then the block is free
	`HBE_ASSERT_NEXT(a_last_idle, done && result.last_element, !busy)

endmodule

bind hashed_token_bigram_embedder hbe_checker u_hbe_checker (.*);

`default_nettype wire
